// File: design/bfsp_pkg.sv
// ----------------------------------------------------------------------------
// bfsp_pkg
// Shared types and constants for the Bellman-Ford shortest path unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bfsp_pkg;

    localparam int MAX_NODES = 64;
    localparam int MAX_EDGES = 256;

    localparam int NODE_W    = $clog2(MAX_NODES);     // node id
    localparam int NCNT_W    = $clog2(MAX_NODES) + 1; // node count / path length
    localparam int EADDR_W   = $clog2(MAX_EDGES);     // edge table address
    localparam int ECNT_W    = $clog2(MAX_EDGES) + 1; // edge fill count
    localparam int COST_W    = 16;
    localparam int DIST_W    = 32;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_ADD   = 2'd1,
        MODE_QUERY = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_FOUND   = 2'd0,
        ST_NO_PATH = 2'd1,
        ST_NEG_CYC = 2'd2,
        ST_RSVD    = 2'd3
    } t_status;

    typedef struct packed {
        logic [NODE_W-1:0]        tail;
        logic [NODE_W-1:0]        head;
        logic signed [COST_W-1:0] cost;
    } t_edge;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_EDGE_RD,
        S_DIST_RD,
        S_RELAX,
        S_FINISH,
        S_WALK,
        S_WALK_CHK,
        S_EMIT_RD,
        S_EMIT,
        S_FAIL
    } t_state;

endpackage

`default_nettype wire

// File: design/bellman_ford_shortest_path_unit.sv
// ----------------------------------------------------------------------------
// bellman_ford_shortest_path_unit
// Single-source shortest path over a loadable directed edge table.
// ----------------------------------------------------------------------------
// Clear and add-edge transactions give no result.
// A query runs node_count-1 relaxation passes plus one check pass over the
// stored edges (one pass in all when node_count is zero or one). Each edge
// of a pass takes an edge read, a distance read and an update with
// write-back on the distance memory, and each pass ends with an end-of-pass
// step. The input stays not ready until the unit is idle again. The unit
// walks the predecessor memory (S_WALK and S_WALK_CHK per node) and streams
// the path out of the stack memory, a stack read then an emit per node, each
// emit waiting for the output register to be free. Failures give one status result.
// The edge table, distances, predecessors and path stack live in
// synchronous memories with registered reads. At the start of every query
// the predecessor-valid flag flops clear and only the start node is reached.
`default_nettype none

module bellman_ford_shortest_path_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [1:0]                          i_mode,
    input  wire logic [bfsp_pkg::NODE_W-1:0]         i_edge_source,
    input  wire logic [bfsp_pkg::NODE_W-1:0]         i_edge_target,
    input  wire logic signed [bfsp_pkg::COST_W-1:0]  i_edge_weight,
    input  wire logic [bfsp_pkg::NODE_W-1:0]         i_start_node,
    input  wire logic [bfsp_pkg::NODE_W-1:0]         i_goal_node,
    input  wire logic [6:0]                          i_node_count,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [bfsp_pkg::NODE_W-1:0]              o_path_node,
    output logic signed [bfsp_pkg::DIST_W-1:0]       o_total_cost,
    output logic [1:0]                               o_status,
    output logic                                     o_last
);
    import bfsp_pkg::*;

    // memories
    t_edge             edge_mem  [MAX_EDGES];
    logic [DIST_W-1:0] dist_mem  [MAX_NODES];
    logic [NODE_W-1:0] pred_mem  [MAX_NODES];
    logic [NODE_W-1:0] stack_mem [MAX_NODES];

    t_state r_state, n_state;

    logic [ECNT_W-1:0]  r_edges_held;
    logic [ECNT_W-1:0]  r_e;
    logic [NCNT_W-1:0]  r_pass_left;
    logic               r_check;
    logic               r_neg_cyc;
    logic [NODE_W-1:0]  r_start, r_goal, r_v;
    logic [NCNT_W-1:0]  r_len;
    logic [MAX_NODES-1:0] r_reached;
    logic [MAX_NODES-1:0] r_pred_valid;

    t_edge              r_edge_q;
    logic [DIST_W-1:0]  r_dist_a, r_dist_b;
    logic [NODE_W-1:0]  r_pred_q;
    logic [NODE_W-1:0]  r_stack_q;

    // control strobes
    logic w_accept, w_out_free, w_improve, w_end_pass, w_walk_done;
    logic w_edge_rd, w_dist_wr, w_emit, w_fail_load;
    logic [NODE_W-1:0] w_dist_addr_a;
    logic [1:0]        w_fail_code;

    // node count saturation and pass count
    logic [NCNT_W-1:0] w_nc, w_passes;
    always_comb begin
        if (i_node_count > 7'(MAX_NODES)) begin
            w_nc = NCNT_W'(MAX_NODES);
        end else begin
            w_nc = NCNT_W'(i_node_count);
        end
        w_passes = (w_nc == '0) ? '0 : w_nc - 1'b1;
    end

    // relaxation datapath
    logic signed [DIST_W:0] w_cand, w_dist_v;
    logic [DIST_W-1:0]      w_cand_sat;
    always_comb begin
        w_cand   = $signed({r_dist_a[DIST_W-1], r_dist_a})
                 + $signed({{(DIST_W+1-COST_W){r_edge_q.cost[COST_W-1]}}, r_edge_q.cost});
        w_dist_v = $signed({r_dist_b[DIST_W-1], r_dist_b});
        if (w_cand[DIST_W] != w_cand[DIST_W-1]) begin
            // saturate toward the sign of the true sum
            w_cand_sat = w_cand[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}}
                                        : {1'b0, {(DIST_W-1){1'b1}}};
        end else begin
            w_cand_sat = w_cand[DIST_W-1:0];
        end
        w_improve = r_reached[r_edge_q.tail]
                 && (!r_reached[r_edge_q.head] || (w_cand < w_dist_v));
    end

    assign w_out_free  = !o_out_valid || i_out_ready;
    assign w_end_pass  = (r_e == r_edges_held);
    assign w_walk_done = !r_pred_valid[r_v] || (r_len == NCNT_W'(MAX_NODES));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_mode == MODE_QUERY) n_state = S_INIT;
            end
            S_INIT:    n_state = S_EDGE_RD;
            S_EDGE_RD: begin
                if (!w_end_pass)  n_state = S_DIST_RD;
                else if (r_check) n_state = S_FINISH;
            end
            S_DIST_RD: n_state = S_RELAX;
            S_RELAX: begin
                n_state = (w_improve && r_check) ? S_FAIL : S_EDGE_RD;
            end
            S_FINISH:   n_state = r_reached[r_goal] ? S_WALK : S_FAIL;
            S_WALK:     n_state = S_WALK_CHK;
            S_WALK_CHK: n_state = w_walk_done ? S_EMIT_RD : S_WALK;
            S_EMIT_RD:  n_state = S_EMIT;
            S_EMIT: begin
                if (w_out_free) n_state = (r_len == NCNT_W'(1)) ? S_IDLE : S_EMIT_RD;
            end
            S_FAIL: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_ready    = 1'b0;
        w_edge_rd     = 1'b0;
        w_dist_wr     = 1'b0;
        w_emit        = 1'b0;
        w_fail_load   = 1'b0;
        w_dist_addr_a = r_goal;
        w_fail_code   = ST_NO_PATH;
        unique case (r_state)
            S_IDLE:    o_in_ready = 1'b1;
            S_EDGE_RD: w_edge_rd = !w_end_pass;
            S_DIST_RD: w_dist_addr_a = r_edge_q.tail;
            S_RELAX:   w_dist_wr = w_improve && !r_check;
            S_EMIT:    w_emit = w_out_free;
            S_FAIL: begin
                w_fail_load = w_out_free;
                w_fail_code = r_neg_cyc ? ST_NEG_CYC : ST_NO_PATH;
            end
            default: ;
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;

    // memories
    always_ff @(posedge i_clk) begin
        if (w_accept && i_mode == MODE_ADD && r_edges_held != ECNT_W'(MAX_EDGES)) begin
            edge_mem[r_edges_held[EADDR_W-1:0]] <= '{tail: i_edge_source,
                                                     head: i_edge_target,
                                                     cost: i_edge_weight};
        end
        if (w_edge_rd) r_edge_q <= edge_mem[r_e[EADDR_W-1:0]];

        if (r_state == S_INIT) begin
            dist_mem[r_start] <= '0;
        end else if (w_dist_wr) begin
            dist_mem[r_edge_q.head] <= w_cand_sat;
        end
        r_dist_a <= dist_mem[w_dist_addr_a];
        r_dist_b <= dist_mem[r_edge_q.head];

        if (w_dist_wr) pred_mem[r_edge_q.head] <= r_edge_q.tail;
        r_pred_q <= pred_mem[r_v];

        if (r_state == S_WALK) stack_mem[r_len[NODE_W-1:0]] <= r_v;
        r_stack_q <= stack_mem[NODE_W'(r_len - 1'b1)];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_edges_held <= '0;
            o_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept && i_mode == MODE_CLEAR) r_edges_held <= '0;
            if (w_accept && i_mode == MODE_ADD && r_edges_held != ECNT_W'(MAX_EDGES)) begin
                r_edges_held <= r_edges_held + 1'b1;
            end
            if (w_emit || w_fail_load)   o_out_valid <= 1'b1;
            else if (i_out_ready)        o_out_valid <= 1'b0;
        end
    end

    // query working registers
    always_ff @(posedge i_clk) begin
        if (w_accept && i_mode == MODE_QUERY) begin
            r_start      <= i_start_node;
            r_goal       <= i_goal_node;
            r_pass_left  <= w_passes;
            r_check      <= (w_passes == '0);
            r_neg_cyc    <= 1'b0;
            r_e          <= '0;
            r_reached    <= MAX_NODES'(1) << i_start_node;
            r_pred_valid <= '0;
        end
        if (r_state == S_EDGE_RD && w_end_pass && !r_check) begin
            r_e         <= '0;
            r_pass_left <= r_pass_left - 1'b1;
            if (r_pass_left == NCNT_W'(1)) r_check <= 1'b1;
        end
        if (r_state == S_RELAX) begin
            r_e <= r_e + 1'b1;
            // an edge that still improves in the check pass means a negative cycle
            if (w_improve && r_check) r_neg_cyc <= 1'b1;
            if (w_dist_wr) begin
                r_reached[r_edge_q.head]    <= 1'b1;
                r_pred_valid[r_edge_q.head] <= 1'b1;
            end
        end
        if (r_state == S_FINISH) begin
            r_v   <= r_goal;
            r_len <= '0;
        end
        if (r_state == S_WALK) r_len <= r_len + 1'b1;
        if (r_state == S_WALK_CHK && !w_walk_done) r_v <= r_pred_q;
        if (w_emit) r_len <= r_len - 1'b1;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            o_path_node  <= r_stack_q;
            o_total_cost <= r_dist_a;
            o_status     <= ST_FOUND;
            o_last       <= (r_len == NCNT_W'(1));
        end else if (w_fail_load) begin
            o_path_node  <= '0;
            o_total_cost <= '0;
            o_status     <= w_fail_code;
            o_last       <= 1'b1;
        end
    end

endmodule

`default_nettype wire

// File: design/bfsp_checker.sv
// ----------------------------------------------------------------------------
// bfsp_checker
// Port-level checks for the shortest path unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bfsp_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                o_out_valid,
    input wire logic                                i_out_ready,
    input wire logic [bfsp_pkg::NODE_W-1:0]         o_path_node,
    input wire logic signed [bfsp_pkg::DIST_W-1:0]  o_total_cost,
    input wire logic [1:0]                          o_status,
    input wire logic                                o_last
);
    import bfsp_pkg::*;

    // a stalled result transaction keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_path_node)
            && $stable(o_total_cost) && $stable(o_status) && $stable(o_last))
        else $error("result changed while stalled");

    // failure statuses are final and zeroed
    a_fail_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_FOUND |->
            o_last && o_path_node == '0 && o_total_cost == '0)
        else $error("malformed failure result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status != ST_RSVD)
        else $error("reserved status");

    // within a path the cost stays the same from one node to the next
    a_cost_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last && o_status == ST_FOUND
            ##1 o_out_valid |-> o_total_cost == $past(o_total_cost)
                && o_status == ST_FOUND)
        else $error("cost changed within a path");

endmodule

bind bellman_ford_shortest_path_unit bfsp_checker u_bfsp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_path_node  (o_path_node),
    .o_total_cost (o_total_cost),
    .o_status     (o_status),
    .o_last       (o_last)
);

`default_nettype wire
